### design/bdpc_pkg.sv
// Package for the block-decomposed prefix counter.
// Holds payload widths, beat types, item codes, the controller state type
// and parameter defaults. No dependencies.
`default_nettype none

package bdpc_pkg;

    localparam int POS_W   = 12;
    localparam int COUNT_W = 32;

    localparam int MAX_VALUE_DEF = 1023;
    localparam int BLOCK_LEN_DEF = 32;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef struct packed {
        logic             action;
        logic [POS_W-1:0] position;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count_at_or_below;
        logic [COUNT_W-1:0] count_above;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SPLIT,
        ST_SWEEP,
        ST_QSUM,
        ST_QOUT
    } state_t;

endpackage

`default_nettype wire

### design/bdpc_stream_if.sv
// Valid/ready stream interface used for the item and result channels.
// The payload type is a parameter; the beat types come from bdpc_pkg.
`default_nettype none

interface bdpc_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/block_decomposed_prefix_counter.sv
// Block-decomposed prefix counter: an insert passes ST_DIV and ST_SPLIT, then sweeps
// n_in <= BLOCK_LEN in-block entries and n_off <= MAX_VALUE/BLOCK_LEN later
// block offsets in parallel, one read-modify-write per memory per cycle.
// A query reads both memories, sums them and loads the result register, waiting while
// it is still full; only then is the next beat taken. An out-of-range insert is dropped
// in the idle state. After reset a clearing pass zeroes both memories; no item is taken
// until it ends. Depends on bdpc_pkg and bdpc_stream_if.
`default_nettype none

module block_decomposed_prefix_counter #(
    parameter int MAX_VALUE = bdpc_pkg::MAX_VALUE_DEF,
    parameter int BLOCK_LEN = bdpc_pkg::BLOCK_LEN_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    bdpc_stream_if.sink         items,
    bdpc_stream_if.source       results
);

    localparam int POS_W      = bdpc_pkg::POS_W;
    localparam int COUNT_W    = bdpc_pkg::COUNT_W;
    localparam int NUM_VALUES = MAX_VALUE + 1;
    localparam int NUM_BLOCKS = MAX_VALUE / BLOCK_LEN + 1;
    localparam int AW         = $clog2(NUM_VALUES);
    localparam int BW         = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    // Reciprocal for the block index: exact for any POS_W-bit value and
    // any block length up to 2^(DIV_SHIFT-POS_W).
    localparam int DIV_SHIFT  = POS_W + 9;
    localparam int MUL_W      = DIV_SHIFT + 1;
    localparam int DIV_MUL    = (1 << DIV_SHIFT) / BLOCK_LEN + 1;
    localparam int PROD_W     = POS_W + MUL_W;
    localparam int END_W      = DIV_SHIFT;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] x);
        return (x == '1) ? x : x + COUNT_W'(1);
    endfunction

    bdpc_pkg::state_t state_reg, state_next;

    // Memories and their registered read data.
    logic [COUNT_W-1:0] wb_mem [0:NUM_VALUES-1];
    logic [COUNT_W-1:0] ob_mem [0:NUM_BLOCKS-1];
    logic [COUNT_W-1:0] w_rdata_reg;
    logic [COUNT_W-1:0] o_rdata_reg;

    // Control registers.
    logic [AW-1:0]      clr_ptr_reg, clr_ptr_next;
    logic               w_act_reg, w_act_next;
    logic               w_pend_reg, w_pend_next;
    logic               o_act_reg, o_act_next;
    logic               o_pend_reg, o_pend_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] total_reg, total_next;

    // Payload registers.
    logic               act_reg, act_next;
    logic [POS_W-1:0]   p_reg, p_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [AW-1:0]      w_ptr_reg, w_ptr_next;
    logic [AW-1:0]      w_last_reg, w_last_next;
    logic [AW-1:0]      w_paddr_reg, w_paddr_next;
    logic [BW-1:0]      o_ptr_reg, o_ptr_next;
    logic [BW-1:0]      o_paddr_reg, o_paddr_next;
    logic [COUNT_W-1:0] pre_reg, pre_next;
    bdpc_pkg::result_t  out_data_reg, out_data_next;

    // Memory port controls.
    logic               w_we, w_re, o_we, o_re;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [BW-1:0]      o_waddr, o_raddr;
    logic [COUNT_W-1:0] w_wdata, o_wdata;
    logic               load_out;
    logic               clear_done;
    logic               sweep_done;
    logic               pos_out_of_range;

    logic [POS_W-1:0]   blk_q;
    logic [END_W-1:0]   blk_end;
    logic [END_W-1:0]   blk_end_c;
    logic               o_empty;
    logic [COUNT_W:0]   pre_sum;

    assign clear_done       = (clr_ptr_reg == AW'(MAX_VALUE));
    assign sweep_done       = !w_act_reg && !w_pend_reg && !o_act_reg && !o_pend_reg;
    assign pos_out_of_range = (32'(items.data.position) > 32'(MAX_VALUE));

    assign blk_q     = prod_reg[DIV_SHIFT +: POS_W];
    assign blk_end   = (END_W'(blk_q) + END_W'(1)) * END_W'(BLOCK_LEN);
    assign blk_end_c = (blk_end > END_W'(NUM_VALUES)) ? END_W'(NUM_VALUES) : blk_end;
    assign o_empty   = (END_W'(blk_q) >= END_W'(NUM_BLOCKS - 1));
    assign pre_sum   = {1'b0, w_rdata_reg} + {1'b0, o_rdata_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdpc_pkg::ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = bdpc_pkg::ST_IDLE;
                end
            end
            bdpc_pkg::ST_IDLE:
            begin
                if (items.valid)
                begin
                    if (items.data.action == bdpc_pkg::ACT_QUERY || !pos_out_of_range)
                    begin
                        state_next = bdpc_pkg::ST_DIV;
                    end
                end
            end
            bdpc_pkg::ST_DIV:
            begin
                state_next = bdpc_pkg::ST_SPLIT;
            end
            bdpc_pkg::ST_SPLIT:
            begin
                state_next = (act_reg == bdpc_pkg::ACT_QUERY) ? bdpc_pkg::ST_QSUM
                                                               : bdpc_pkg::ST_SWEEP;
            end
            bdpc_pkg::ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = bdpc_pkg::ST_IDLE;
                end
            end
            bdpc_pkg::ST_QSUM:
            begin
                state_next = bdpc_pkg::ST_QOUT;
            end
            bdpc_pkg::ST_QOUT:
            begin
                if (load_out)
                begin
                    state_next = bdpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdpc_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake and memory port controls.
    always_comb
    begin
        items.ready = (state_reg == bdpc_pkg::ST_IDLE);
        load_out    = (state_reg == bdpc_pkg::ST_QOUT) && (!out_valid_reg || results.ready);

        w_we    = 1'b0;
        w_waddr = w_paddr_reg;
        w_wdata = sat_inc(w_rdata_reg);
        o_we    = 1'b0;
        o_waddr = o_paddr_reg;
        o_wdata = sat_inc(o_rdata_reg);
        w_re    = 1'b0;
        w_raddr = w_ptr_reg;
        o_re    = 1'b0;
        o_raddr = o_ptr_reg;

        if (state_reg == bdpc_pkg::ST_CLEAR)
        begin
            w_we    = 1'b1;
            w_waddr = clr_ptr_reg;
            w_wdata = '0;
            o_we    = (clr_ptr_reg <= AW'(NUM_BLOCKS - 1));
            o_waddr = BW'(clr_ptr_reg);
            o_wdata = '0;
        end
        else
        begin
            w_we = w_pend_reg;
            o_we = o_pend_reg;
        end

        if (state_reg == bdpc_pkg::ST_SPLIT && act_reg == bdpc_pkg::ACT_QUERY)
        begin
            w_re    = 1'b1;
            w_raddr = AW'(p_reg);
            o_re    = 1'b1;
            o_raddr = BW'(blk_q);
        end
        else if (state_reg == bdpc_pkg::ST_SWEEP)
        begin
            w_re = w_act_reg;
            o_re = o_act_reg;
        end
    end

    // Datapath and sweep pointers.
    always_comb
    begin
        clr_ptr_next   = clr_ptr_reg;
        w_act_next     = w_act_reg;
        o_act_next     = o_act_reg;
        w_pend_next    = (state_reg == bdpc_pkg::ST_SWEEP) && w_act_reg;
        o_pend_next    = (state_reg == bdpc_pkg::ST_SWEEP) && o_act_reg;
        w_paddr_next   = w_ptr_reg;
        o_paddr_next   = o_ptr_reg;
        total_next     = total_reg;
        act_next       = act_reg;
        p_next         = p_reg;
        prod_next      = PROD_W'(p_reg) * PROD_W'(DIV_MUL);
        w_ptr_next     = w_ptr_reg;
        w_last_next    = w_last_reg;
        o_ptr_next     = o_ptr_reg;
        pre_next       = pre_sum[COUNT_W] ? '1 : pre_sum[COUNT_W-1:0];
        out_valid_next = out_valid_reg && !results.ready;
        out_data_next  = out_data_reg;

        if (state_reg == bdpc_pkg::ST_CLEAR)
        begin
            clr_ptr_next = clr_ptr_reg + AW'(1);
        end

        if (items.valid && items.ready)
        begin
            act_next = items.data.action;
            p_next   = pos_out_of_range ? POS_W'(MAX_VALUE) : items.data.position;
        end

        if (state_reg == bdpc_pkg::ST_SPLIT && act_reg == bdpc_pkg::ACT_INSERT)
        begin
            w_ptr_next  = AW'(p_reg);
            w_last_next = AW'(blk_end_c - END_W'(1));
            w_act_next  = 1'b1;
            o_ptr_next  = BW'(blk_q + POS_W'(1));
            o_act_next  = !o_empty;
            total_next  = sat_inc(total_reg);
        end

        if (state_reg == bdpc_pkg::ST_SWEEP)
        begin
            if (w_act_reg)
            begin
                if (w_ptr_reg == w_last_reg)
                begin
                    w_act_next = 1'b0;
                end
                else
                begin
                    w_ptr_next = w_ptr_reg + AW'(1);
                end
            end
            if (o_act_reg)
            begin
                if (o_ptr_reg == BW'(NUM_BLOCKS - 1))
                begin
                    o_act_next = 1'b0;
                end
                else
                begin
                    o_ptr_next = o_ptr_reg + BW'(1);
                end
            end
        end

        if (load_out)
        begin
            out_valid_next                  = 1'b1;
            out_data_next.count_at_or_below = pre_reg;
            out_data_next.count_above       = (pre_reg > total_reg) ? '0
                                                                    : total_reg - pre_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdpc_pkg::ST_CLEAR;
            clr_ptr_reg   <= '0;
            w_act_reg     <= 1'b0;
            w_pend_reg    <= 1'b0;
            o_act_reg     <= 1'b0;
            o_pend_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            w_act_reg     <= w_act_next;
            w_pend_reg    <= w_pend_next;
            o_act_reg     <= o_act_next;
            o_pend_reg    <= o_pend_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        p_reg        <= p_next;
        prod_reg     <= prod_next;
        w_ptr_reg    <= w_ptr_next;
        w_last_reg   <= w_last_next;
        w_paddr_reg  <= w_paddr_next;
        o_ptr_reg    <= o_ptr_next;
        o_paddr_reg  <= o_paddr_next;
        pre_reg      <= pre_next;
        out_data_reg <= out_data_next;
    end

    // In-block prefix count memory.
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wb_mem[w_waddr] <= w_wdata;
        end
        if (w_re)
        begin
            w_rdata_reg <= wb_mem[w_raddr];
        end
    end

    // Block offset memory.
    always_ff @(posedge clk)
    begin
        if (o_we)
        begin
            ob_mem[o_waddr] <= o_wdata;
        end
        if (o_re)
        begin
            o_rdata_reg <= ob_mem[o_raddr];
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

`ifndef SYNTHESIS
    // A sweep write never lands on the entry being read in the same cycle.
    a_no_same_entry_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("in-block read and write hit the same entry");

    // In-block writes of an insert stay inside the value's block.
    a_write_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        w_pend_reg |-> (w_paddr_reg <= w_last_reg))
        else $error("in-block write beyond end of block");

    // A new result is loaded only when the output register is free.
    a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || results.ready))
        else $error("result overwritten before it was taken");

    // The total never decreases.
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bdpc_pkg::ST_CLEAR) |=> (total_reg >= $past(total_reg)))
        else $error("total count decreased");

    // No beat is taken while the memories are being cleared.
    a_no_beat_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bdpc_pkg::ST_CLEAR) |-> !items.ready)
        else $error("item taken during clearing pass");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking bench for block_decomposed_prefix_counter: drives insert and query beats
// and compares every query result against a software histogram kept in the bench.
// Depends on bdpc_pkg, bdpc_stream_if and the block itself.
`default_nettype none

module testbench;

    localparam int POS_W      = bdpc_pkg::POS_W;
    localparam int COUNT_W    = bdpc_pkg::COUNT_W;
    localparam int MAX_VAL    = bdpc_pkg::MAX_VALUE_DEF;
    localparam int SPAN       = bdpc_pkg::BLOCK_LEN_DEF;
    localparam int NUM_BLK    = MAX_VAL / SPAN + 1;
    localparam int NUM_RANDOM = 1150;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    logic clk;
    logic rst_n;

    bdpc_stream_if #(.data_t(bdpc_pkg::item_t))   item_ch ();
    bdpc_stream_if #(.data_t(bdpc_pkg::result_t)) result_ch ();

    block_decomposed_prefix_counter u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch)
    );

    // Bench copy of the histogram.
    logic [COUNT_W-1:0] in_block_prefix [0:MAX_VAL];
    logic [COUNT_W-1:0] block_base [0:NUM_BLK-1];
    logic [COUNT_W-1:0] inserted_total;

    bdpc_pkg::item_t   pending_items [$];
    bdpc_pkg::result_t expected_counts [$];

    int items_taken;
    int total_items;
    int error_count;
    int insert_count;
    int dropped_inserts;
    int query_count;
    int results_checked;

    int send_idle_tbl [4] = '{0, 59, 0, 34};
    int recv_stall_tbl[4] = '{0, 0, 59, 34};
    int phase_idx;

    always_comb
    begin
        if (total_items == 0)
            phase_idx = 0;
        else if ((items_taken * 4) / total_items > 3)
            phase_idx = 3;
        else
            phase_idx = (items_taken * 4) / total_items;
    end

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [COUNT_W-1:0] sat_bump(input logic [COUNT_W-1:0] x);
        return (x == COUNT_SAT) ? x : x + COUNT_W'(1);
    endfunction

    // Applies one accepted beat to the histogram; a query queues the counts it must return.
    function automatic void histogram_update(input bdpc_pkg::item_t it);
        int                p;
        int                blk;
        int                stop;
        logic [COUNT_W:0]  prefix_sum;
        bdpc_pkg::result_t res;
        if (it.action == bdpc_pkg::ACT_INSERT)
        begin
            insert_count++;
            p = it.position;
            if (p > MAX_VAL)
            begin
                dropped_inserts++;
                return;
            end
            blk  = p / SPAN;
            stop = (blk + 1) * SPAN;
            if (stop > MAX_VAL + 1)
                stop = MAX_VAL + 1;
            for (int j = p; j < stop; j++)
                in_block_prefix[j] = sat_bump(in_block_prefix[j]);
            for (int j = blk + 1; j < NUM_BLK; j++)
                block_base[j] = sat_bump(block_base[j]);
            inserted_total = sat_bump(inserted_total);
        end
        else
        begin
            query_count++;
            p = (it.position > MAX_VAL) ? MAX_VAL : it.position;
            prefix_sum = {1'b0, in_block_prefix[p]} + {1'b0, block_base[p / SPAN]};
            res.count_at_or_below = prefix_sum[COUNT_W] ? COUNT_SAT : prefix_sum[COUNT_W-1:0];
            res.count_above = (res.count_at_or_below > inserted_total) ? '0 :
                              inserted_total - res.count_at_or_below;
            expected_counts.insert(expected_counts.size(), res);
        end
    endfunction

    function automatic void check_counts(input bdpc_pkg::result_t got);
        bdpc_pkg::result_t want;
        if (expected_counts.size() == 0)
        begin
            $display("%0t: unexpected result beat, expected none, got below=%0d above=%0d",
                     $time, got.count_at_or_below, got.count_above);
            error_count++;
            return;
        end
        want = expected_counts.pop_front();
        results_checked++;
        if (got.count_at_or_below !== want.count_at_or_below)
        begin
            $display("%0t: count_at_or_below mismatch, expected %0d, got %0d",
                     $time, want.count_at_or_below, got.count_at_or_below);
            error_count++;
        end
        if (got.count_above !== want.count_above)
        begin
            $display("%0t: count_above mismatch, expected %0d, got %0d",
                     $time, want.count_above, got.count_above);
            error_count++;
        end
    endfunction

    function automatic logic [POS_W-1:0] pick_in_range();
        int blk;
        int offs [4] = '{0, 1, SPAN - 2, SPAN - 1};
        // A quarter of the values land on block edges, where the sweeps start and stop.
        if ($urandom_range(3) == 0)
        begin
            blk = $urandom_range(NUM_BLK - 1);
            return POS_W'(blk * SPAN + offs[$urandom_range(3)]);
        end
        return POS_W'($urandom_range(MAX_VAL));
    endfunction

    function automatic bdpc_pkg::item_t make_item(input logic act, input int pos);
        bdpc_pkg::item_t it;
        it.action   = act;
        it.position = POS_W'(pos);
        return it;
    endfunction

    function automatic bdpc_pkg::item_t random_item();
        int unsigned     pick;
        bdpc_pkg::item_t it;
        pick = $urandom_range(99);
        if (pick < 45)
            it = make_item(bdpc_pkg::ACT_INSERT, pick_in_range());
        else if (pick < 50)
            it = make_item(bdpc_pkg::ACT_INSERT,
                           $urandom_range((1 << POS_W) - 1, MAX_VAL + 1));
        else if (pick < 90)
            it = make_item(bdpc_pkg::ACT_QUERY, pick_in_range());
        else
            it = make_item(bdpc_pkg::ACT_QUERY,
                           $urandom_range((1 << POS_W) - 1, MAX_VAL + 1));
        return it;
    endfunction

    // Driver: presents the next pending item when the channel is free, with random idle gaps in some phases.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                histogram_update(item_ch.data);
                items_taken <= items_taken + 1;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_items.size() > 0 &&
                    $urandom_range(99) >= send_idle_tbl[phase_idx])
                begin
                    item_ch.valid <= 1'b1;
                    item_ch.data  <= pending_items.pop_front();
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes result beats under random back-pressure and checks them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
                check_counts(result_ch.data);
            result_ch.ready <= ($urandom_range(99) >= recv_stall_tbl[phase_idx]);
        end
    end

    initial
    begin
        int   directed_pos [24];
        logic directed_act [24];
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        rst_n           = 1'b0;
        items_taken     = 0;
        total_items     = 0;
        error_count     = 0;
        insert_count    = 0;
        dropped_inserts = 0;
        query_count     = 0;
        results_checked = 0;
        inserted_total  = '0;
        for (int j = 0; j <= MAX_VAL; j++)
            in_block_prefix[j] = '0;
        for (int j = 0; j < NUM_BLK; j++)
            block_base[j] = '0;

        // Queries on the empty histogram, inserts at both ends and across a block edge,
        // out-of-range inserts that must be dropped, then queries around the first and last block edges.
        directed_pos = '{0, MAX_VAL, 4095,
                         0, SPAN - 1, SPAN, MAX_VAL, MAX_VAL - SPAN + 1, MAX_VAL + 1,
                         4095, 2048, 0,
                         0, SPAN - 2, SPAN - 1, SPAN, SPAN + 1, MAX_VAL - SPAN,
                         MAX_VAL - SPAN + 1, MAX_VAL - 1, MAX_VAL, MAX_VAL + 1, 4095, 2047};
        directed_act = '{bdpc_pkg::ACT_QUERY, bdpc_pkg::ACT_QUERY, bdpc_pkg::ACT_QUERY,
                         bdpc_pkg::ACT_INSERT, bdpc_pkg::ACT_INSERT, bdpc_pkg::ACT_INSERT,
                         bdpc_pkg::ACT_INSERT, bdpc_pkg::ACT_INSERT, bdpc_pkg::ACT_INSERT,
                         bdpc_pkg::ACT_INSERT, bdpc_pkg::ACT_INSERT, bdpc_pkg::ACT_INSERT,
                         bdpc_pkg::ACT_QUERY, bdpc_pkg::ACT_QUERY, bdpc_pkg::ACT_QUERY,
                         bdpc_pkg::ACT_QUERY, bdpc_pkg::ACT_QUERY, bdpc_pkg::ACT_QUERY,
                         bdpc_pkg::ACT_QUERY, bdpc_pkg::ACT_QUERY, bdpc_pkg::ACT_QUERY,
                         bdpc_pkg::ACT_QUERY, bdpc_pkg::ACT_QUERY, bdpc_pkg::ACT_QUERY};
        for (int j = 0; j < 24; j++)
            pending_items.insert(pending_items.size(),
                                 make_item(directed_act[j], directed_pos[j]));
        for (int j = 0; j < NUM_RANDOM; j++)
            pending_items.insert(pending_items.size(), random_item());
        total_items = pending_items.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken < total_items)
            @(posedge clk);
        while (expected_counts.size() > 0)
            @(posedge clk);
        // The last beat may be a long insert sweep; let it drain before closing out.
        repeat (60) @(posedge clk);

        $display("Run covered %0d inserts (%0d dropped as out of range) and %0d queries,",
                 insert_count, dropped_inserts, query_count);
        $display("with %0d result beats checked under four pacing phases.", results_checked);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
design/bdpc_pkg.sv
design/bdpc_stream_if.sv
design/block_decomposed_prefix_counter.sv
tb/testbench.sv
